// ----- rtl/rca_pkg.sv -----
// Shared types and codes for the register cache allocator.
// No dependencies; every other file imports this package.
`default_nettype none

package rca_pkg;

    // Record kinds
    localparam logic [2:0] KIND_SPILL    = 3'd0;
    localparam logic [2:0] KIND_MOVE     = 3'd1;
    localparam logic [2:0] KIND_RESTORE  = 3'd2;
    localparam logic [2:0] KIND_ASSIGNED = 3'd3;
    localparam logic [2:0] KIND_ERROR    = 3'd4;

    // Request actions
    localparam logic ACT_ANY  = 1'b0;
    localparam logic ACT_BIND = 1'b1;

    // Input item
    typedef struct packed {
        logic       action;
        logic [6:0] vreg;
        logic [3:0] target_reg;
    } req_t;

    // Result item
    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] phys_reg;
        logic [3:0] source_reg;
        logic [6:0] slot;
        logic [6:0] owner_vreg;
        logic       last;
    } rsp_t;

    // Classified request handed from front to back
    typedef struct packed {
        logic       err;
        logic       action;
        logic [6:0] vreg;
        logic [3:0] target_reg;
    } cmd_t;

    // Queue head as seen by the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_head_t;

endpackage

`default_nettype wire

// ----- rtl/rca_front.sv -----
// Front end: accepts requests, classifies errors and queues them.
// Depends on rca_pkg.
`default_nettype none

module rca_front #(
    parameter int NUM_VIRT = 128,
    parameter int NUM_PHYS = 9
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire rca_pkg::req_t     in_data,
    output rca_pkg::cmd_head_t     head,
    input  wire logic              pop
);
    import rca_pkg::*;

    localparam int VW = (NUM_VIRT > 2) ? $clog2(NUM_VIRT) : 1;
    localparam int CW = ((VW > 7) ? VW : 7) + 1;
    localparam int TW = (($clog2(NUM_PHYS + 1) > 4) ? $clog2(NUM_PHYS + 1) : 4) + 1;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    cmd_t       cls;

    // Classify the incoming item
    always_comb
    begin
        cls.action     = in_data.action;
        cls.vreg       = in_data.vreg;
        cls.target_reg = in_data.target_reg;
        cls.err = (in_data.vreg == 7'd0)
               || (CW'(in_data.vreg) >= CW'(NUM_VIRT))
               || ((in_data.action == ACT_BIND)
                   && ((in_data.target_reg == 4'd0)
                       || (TW'(in_data.target_reg) > TW'(NUM_PHYS))));
    end

    assign in_stall   = (count_reg == 2'd2);
    assign push       = in_valid && !in_stall;
    assign head.valid = (count_reg != 2'd0);
    assign head.cmd   = q_reg[rd_ptr_reg];

    // Hold queued items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != 2'd0) else $error("pop from empty queue");
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 |-> !push) else $error("push into full queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3) else $error("queue count overflow");

endmodule

`default_nettype wire

// ----- rtl/rca_back.sv -----
// Back end: sequences one request at a time over the vreg table and the
// physical register file, emitting spill, move, restore, assigned and error records.
// Depends on rca_pkg.
`default_nettype none

module rca_back #(
    parameter int NUM_VIRT = 128,
    parameter int NUM_PHYS = 9
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire rca_pkg::cmd_head_t head,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output rca_pkg::rsp_t           out_data
);
    import rca_pkg::*;

    localparam int VW = (NUM_VIRT > 2) ? $clog2(NUM_VIRT) : 1;
    localparam int PW = $clog2(NUM_PHYS + 1);

    typedef enum logic [2:0] {S_IDLE, S_RDV, S_RDW, S_MV, S_ASG, S_ERR} state_t;

    typedef struct packed {
        logic [PW-1:0] home;
        logic [6:0]    slot;
    } ventry_t;

    // Vreg table, one write and one read port
    ventry_t        mem [NUM_VIRT];
    logic [NUM_VIRT-1:0] vld_reg;
    ventry_t        rd_data_reg;
    logic           rd_vld_reg;
    logic [VW-1:0]  rd_addr;
    logic           mem_we;
    logic [VW-1:0]  mem_waddr;
    ventry_t        mem_wdata;

    state_t         state_reg;
    cmd_t           cur_reg;
    logic [PW-1:0]  p_reg;
    logic [PW-1:0]  home_v_reg;
    logic [6:0]     slot_v_reg;
    logic [6:0]     w_reg;
    logic [6:0]     owner_reg [NUM_PHYS+1];
    logic [31:0]    last_use_reg [NUM_PHYS+1];
    logic [31:0]    use_cnt_reg;
    logic [6:0]     next_slot_reg;
    logic           out_valid_reg;
    rsp_t           out_reg;

    logic [PW-1:0]  rd_home;
    logic [6:0]     rd_slot;
    logic           free_found;
    logic [PW-1:0]  free_idx;
    logic           vic_found;
    logic [PW-1:0]  vic_idx;
    logic [PW-1:0]  p_pick;
    logic [6:0]     owner_pick;
    logic           out_free;
    logic           mv_emit;
    logic [6:0]     slot_w;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign pop       = (state_reg == S_IDLE) && head.valid;
    assign mv_emit   = (home_v_reg != '0) || (slot_v_reg != 7'd0);

    // Decode table read and scan the physical registers
    always_comb
    begin
        rd_home    = rd_vld_reg ? rd_data_reg.home : '0;
        rd_slot    = rd_vld_reg ? rd_data_reg.slot : 7'd0;
        free_found = 1'b0;
        free_idx   = PW'(1);
        vic_found  = 1'b0;
        vic_idx    = PW'(1);
        for (int i = NUM_PHYS; i >= 1; i--)
        begin
            if (owner_reg[i] == 7'd0)
            begin
                free_found = 1'b1;
                free_idx   = PW'(i);
            end
            if ((owner_reg[i] != 7'd0)
                && ((use_cnt_reg - last_use_reg[i]) >= 32'(NUM_PHYS)))
            begin
                vic_found = 1'b1;
                vic_idx   = PW'(i);
            end
        end
        if (cur_reg.action == ACT_BIND)
        begin
            p_pick = PW'(cur_reg.target_reg);
        end
        else if (rd_home != '0)
        begin
            p_pick = rd_home;
        end
        else if (free_found)
        begin
            p_pick = free_idx;
        end
        else
        begin
            p_pick = vic_found ? vic_idx : PW'(1);
        end
        owner_pick = owner_reg[p_pick];
        slot_w     = (rd_slot != 7'd0) ? rd_slot : next_slot_reg;
    end

    // Select table address and write data
    always_comb
    begin
        rd_addr   = VW'(cur_reg.vreg);
        mem_we    = 1'b0;
        mem_waddr = VW'(cur_reg.vreg);
        mem_wdata = '{home: '0, slot: slot_w};
        unique case (state_reg)
            S_IDLE: rd_addr = VW'(head.cmd.vreg);
            S_RDV:  rd_addr = VW'(owner_pick);
            S_RDW:
            begin
                rd_addr   = VW'(w_reg);
                mem_we    = out_free;
                mem_waddr = VW'(w_reg);
                mem_wdata = '{home: '0, slot: slot_w};
            end
            S_MV:
            begin
                mem_we    = !mv_emit || out_free;
                mem_wdata = '{home: p_reg, slot: slot_v_reg};
            end
            S_ASG, S_ERR: rd_addr = VW'(cur_reg.vreg);
            default: rd_addr = VW'(cur_reg.vreg);
        endcase
    end

    // Table storage and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Table entry valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= vld_reg[rd_addr] && !(mem_we && (mem_waddr == rd_addr));
            if (mem_we)
            begin
                vld_reg[mem_waddr] <= 1'b1;
            end
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cur_reg       <= '0;
            p_reg         <= '0;
            home_v_reg    <= '0;
            slot_v_reg    <= 7'd0;
            w_reg         <= 7'd0;
            use_cnt_reg   <= 32'd1;
            next_slot_reg <= 7'd1;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            for (int i = 0; i <= NUM_PHYS; i++)
            begin
                owner_reg[i]    <= 7'd0;
                last_use_reg[i] <= 32'd0;
            end
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (head.valid)
                    begin
                        cur_reg   <= head.cmd;
                        state_reg <= head.cmd.err ? S_ERR : S_RDV;
                    end
                end
                S_RDV:
                begin
                    p_reg      <= p_pick;
                    home_v_reg <= rd_home;
                    slot_v_reg <= rd_slot;
                    w_reg      <= owner_pick;
                    if (rd_home == p_pick)
                    begin
                        state_reg <= S_ASG;
                    end
                    else if (owner_pick != 7'd0)
                    begin
                        state_reg <= S_RDW;
                    end
                    else
                    begin
                        state_reg <= S_MV;
                    end
                end
                S_RDW:
                begin
                    if (out_free)
                    begin
                        if (rd_slot == 7'd0)
                        begin
                            next_slot_reg <= (next_slot_reg == 7'd127) ? 7'd1
                                                                        : next_slot_reg + 7'd1;
                        end
                        out_valid_reg      <= 1'b1;
                        out_reg            <= '0;
                        out_reg.kind       <= KIND_SPILL;
                        out_reg.phys_reg   <= 4'(p_reg);
                        out_reg.slot       <= slot_w;
                        out_reg.owner_vreg <= w_reg;
                        owner_reg[p_reg]   <= 7'd0;
                        state_reg          <= S_MV;
                    end
                end
                S_MV:
                begin
                    if (!mv_emit || out_free)
                    begin
                        if (mv_emit)
                        begin
                            out_valid_reg      <= 1'b1;
                            out_reg            <= '0;
                            out_reg.phys_reg   <= 4'(p_reg);
                            out_reg.owner_vreg <= cur_reg.vreg;
                            if (home_v_reg != '0)
                            begin
                                out_reg.kind       <= KIND_MOVE;
                                out_reg.source_reg <= 4'(home_v_reg);
                            end
                            else
                            begin
                                out_reg.kind <= KIND_RESTORE;
                                out_reg.slot <= slot_v_reg;
                            end
                        end
                        if (home_v_reg != '0)
                        begin
                            owner_reg[home_v_reg] <= 7'd0;
                        end
                        owner_reg[p_reg] <= cur_reg.vreg;
                        state_reg        <= S_ASG;
                    end
                end
                S_ASG:
                begin
                    if (out_free)
                    begin
                        out_valid_reg       <= 1'b1;
                        out_reg             <= '0;
                        out_reg.kind        <= KIND_ASSIGNED;
                        out_reg.phys_reg    <= 4'(p_reg);
                        out_reg.owner_vreg  <= cur_reg.vreg;
                        out_reg.last        <= 1'b1;
                        last_use_reg[p_reg] <= use_cnt_reg;
                        use_cnt_reg         <= use_cnt_reg + 32'd1;
                        state_reg           <= S_IDLE;
                    end
                end
                S_ERR:
                begin
                    if (out_free)
                    begin
                        out_valid_reg      <= 1'b1;
                        out_reg            <= '0;
                        out_reg.kind       <= KIND_ERROR;
                        out_reg.owner_vreg <= cur_reg.vreg;
                        out_reg.last       <= 1'b1;
                        state_reg          <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.kind == KIND_ERROR |-> out_reg.last)
        else $error("error record not last");
    a_asg_owner: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ASG |-> owner_reg[p_reg] == cur_reg.vreg)
        else $error("assigned register not owned by request");
    a_stamp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ASG && out_free |=> use_cnt_reg == $past(use_cnt_reg) + 32'd1)
        else $error("use counter not advanced");
    a_slot_nz: assert property (@(posedge clk) disable iff (!rst_n)
        next_slot_reg != 7'd0) else $error("slot counter hit zero");

endmodule

`default_nettype wire

// ----- rtl/register_cache_allocator_core.sv -----
// Register cache allocator: maps virtual registers onto NUM_PHYS physical
// registers, spilling the lowest-index register whose last use is at least
// NUM_PHYS references old. Each request yields one to three records, the last
// flagged. A request whose vreg or target is out of range goes from pop straight to
// its error record in the back end; other requests walk pop, table read, optional
// owner read for a spill, optional move/restore and assigned, one step per cycle
// unless the output stalls; the order is set by the single read port of the vreg table.
// A two-entry queue lets requests be taken while the back end works.
// Depends on rca_pkg, rca_front, rca_back.
`default_nettype none

module register_cache_allocator_core #(
    parameter int NUM_VIRT = 128,
    parameter int NUM_PHYS = 9
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire rca_pkg::req_t  in_data,
    output logic                out_valid,
    input  wire logic           out_stall,
    output rca_pkg::rsp_t       out_data
);
    import rca_pkg::*;

    cmd_head_t head;
    logic      pop;

    rca_front #(.NUM_VIRT(NUM_VIRT), .NUM_PHYS(NUM_PHYS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .head     (head),
        .pop      (pop)
    );

    rca_back #(.NUM_VIRT(NUM_VIRT), .NUM_PHYS(NUM_PHYS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ----- tb/sv/register_cache_allocator_core_test.sv -----
// Testbench for register_cache_allocator_core: drives requests, predicts and checks every record.
// Depends on rca_pkg and the register_cache_allocator_core RTL.
`timescale 1ns / 100ps

module register_cache_allocator_core_test;
    import rca_pkg::*;

    localparam int NV = 128;
    localparam int NP = 9;
    localparam int LIMIT = 200000;

    // Holds allocator state and the queue of expected records
    class alloc_scoreboard;
        logic [3:0]  home [NV];
        logic [6:0]  vslot [NV];
        logic [6:0]  owner [NP + 1];
        logic [31:0] stamp_of [NP + 1];
        logic [31:0] use_cnt;
        logic [6:0]  slot_next;
        rsp_t        pending [$];
        int          errors;

        function new();
            for (int i = 0; i < NV; i++)
            begin
                home[i] = 0;
                vslot[i] = 0;
            end
            for (int i = 0; i <= NP; i++)
            begin
                owner[i] = 0;
                stamp_of[i] = 0;
            end
            use_cnt = 1;
            slot_next = 1;
            errors = 0;
        endfunction

        function void push(logic [2:0] k, logic [3:0] p, logic [3:0] s,
                           logic [6:0] sl, logic [6:0] o);
            rsp_t r;
            r.kind = k;
            r.phys_reg = p;
            r.source_reg = s;
            r.slot = sl;
            r.owner_vreg = o;
            r.last = 1'b0;
            pending.push_back(r);
        endfunction

        // Evict whatever occupies register p
        function void evict(int p);
            int w;
            w = owner[p];
            if (w == 0)
                return;
            if (vslot[w] == 0)
            begin
                vslot[w] = slot_next;
                slot_next = slot_next + 7'd1;
                if (slot_next == 0)
                    slot_next = 1;
            end
            push(KIND_SPILL, 4'(p), 4'd0, vslot[w], 7'(w));
            home[w] = 0;
            owner[p] = 0;
        endfunction

        function void place(int v, int p);
            int h;
            if (home[v] != p)
            begin
                evict(p);
                h = home[v];
                if (h != 0 && h <= NP)
                begin
                    push(KIND_MOVE, 4'(p), 4'(h), 7'd0, 7'(v));
                    owner[h] = 0;
                end
                else if (vslot[v] != 0)
                    push(KIND_RESTORE, 4'(p), 4'd0, vslot[v], 7'(v));
                owner[p] = 7'(v);
                home[v] = 4'(p);
            end
            stamp_of[p] = use_cnt;
            use_cnt = use_cnt + 1;
            push(KIND_ASSIGNED, 4'(p), 4'd0, 7'd0, 7'(v));
        endfunction

        function int first_free();
            for (int i = 1; i <= NP; i++)
                if (owner[i] == 0)
                    return i;
            return 0;
        endfunction

        // Note an accepted request and predict its records
        function void note_request(req_t q);
            int v, t, p;
            v = q.vreg;
            t = q.target_reg;
            if (v == 0 || v >= NV || (q.action == ACT_BIND && (t == 0 || t > NP)))
                push(KIND_ERROR, 4'd0, 4'd0, 7'd0, q.vreg);
            else if (q.action == ACT_BIND)
                place(v, t);
            else if (home[v] != 0 && home[v] <= NP)
                place(v, home[v]);
            else
            begin
                p = first_free();
                if (p == 0)
                begin
                    p = 1;
                    for (int i = NP; i >= 1; i--)
                        if (owner[i] != 0 && (use_cnt - stamp_of[i]) >= NP)
                            p = i;
                    evict(p);
                    p = first_free();
                    if (p == 0)
                        p = 1;
                end
                place(v, p);
            end
            pending[$].last = 1'b1;
        endfunction

        // Compare a result against the oldest expectation
        function void check_record(rsp_t got);
            rsp_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected record %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $write("record mismatch: expected k%0d p%0d s%0d sl%0d o%0d l%0d, ",
                        want.kind, want.phys_reg, want.source_reg, want.slot,
                        want.owner_vreg, want.last);
                    $display("got k%0d p%0d s%0d sl%0d o%0d l%0d",
                        got.kind, got.phys_reg, got.source_reg, got.slot,
                        got.owner_vreg, got.last);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    req_t in_data;
    logic out_valid;
    logic out_stall;
    rsp_t out_data;

    alloc_scoreboard board;
    int src_idle;
    int dst_idle;
    int cycles;

    register_cache_allocator_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Check accepted records and drive receiver stalls
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_record(out_data);
            out_stall <= ($urandom_range(99) < dst_idle);
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Send one request, with random idle cycles ahead of it
    task automatic send_request(logic act, logic [6:0] v, logic [3:0] t);
        req_t q;
        while ($urandom_range(99) < src_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        q.action = act;
        q.vreg = v;
        q.target_reg = t;
        in_valid <= 1'b1;
        in_data <= q;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_request(q);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // Mostly in-range requests over a small vreg pool to force spills
    task automatic random_requests(int count);
        logic [6:0] v;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) == 0)
                send_request(1'($urandom_range(1)), 7'($urandom_range(127)),
                             4'($urandom_range(15)));
            else
            begin
                if ($urandom_range(3) == 0)
                    v = 7'($urandom_range(1, 127));
                else
                    v = 7'($urandom_range(1, 20));
                send_request(1'($urandom_range(1)), v, 4'($urandom_range(1, NP)));
            end
        end
    endtask

    initial
    begin
        board = new();
        cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        src_idle = 29;
        dst_idle = 70;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: errors, extremes, fill, spill, move, restore, remap
        send_request(ACT_ANY, 7'd0, 4'd0);
        send_request(ACT_BIND, 7'd5, 4'd0);
        send_request(ACT_BIND, 7'd5, 4'd10);
        send_request(ACT_BIND, 7'd5, 4'd15);
        send_request(ACT_BIND, 7'd127, 4'd9);
        for (int i = 1; i <= 10; i++)
            send_request(ACT_ANY, i[6:0], 4'd0);
        send_request(ACT_ANY, 7'd1, 4'd0);
        send_request(ACT_BIND, 7'd2, 4'd1);
        send_request(ACT_BIND, 7'd2, 4'd1);
        send_request(ACT_BIND, 7'd3, 4'd9);
        send_request(ACT_ANY, 7'd127, 4'd15);
        send_request(ACT_BIND, 7'd100, 4'd5);
        drain();

        random_requests(43);
        drain();
        src_idle = 70;
        dst_idle = 29;
        random_requests(43);
        drain();
        src_idle = 0;
        dst_idle = 0;
        random_requests(43);
        drain();

        if (board.errors == 0 && board.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
